[src/sfdg_pkg.sv]
// Shared constants, types and lookup functions for the scanned gauge display.
// No dependencies; imported by scanned_four_digit_gauge_display_top.
package sfdg_pkg;

  localparam int unsigned VALUE_W   = 14;
  localparam int unsigned PRESS_W   = 16;
  localparam int unsigned PROD_W    = 28;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [VALUE_W-1:0] VALUE_MAX     = 14'd9999;
  localparam logic [VALUE_W-1:0] LOW_THR_RST   = 14'd180;
  localparam logic [VALUE_W-1:0] HIGH_THR_RST  = 14'd200;
  localparam logic [VALUE_W-1:0] BAR_STEP      = 14'd20;
  localparam logic [3:0]         BAR_MAX_COUNT = 4'd8;
  localparam logic [7:0]         DP_BIT        = 8'h80;

  // Reciprocal multipliers for constant division of values up to 9999
  localparam logic [VALUE_W-1:0] RECIP_1000 = 14'd8389;  // shift 23
  localparam logic [VALUE_W-1:0] RECIP_100  = 14'd5243;  // shift 19
  localparam logic [VALUE_W-1:0] RECIP_10   = 14'd6554;  // shift 16

  typedef enum logic [1:0] {
    DIG_THOUSANDS = 2'd0,
    DIG_HUNDREDS  = 2'd1,
    DIG_TENS      = 2'd2,
    DIG_UNITS     = 2'd3
  } digit_pos_t;

  typedef enum logic {
    REG_LOW_THR  = 1'b0,
    REG_HIGH_THR = 1'b1
  } reg_idx_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] bar_fill(input logic [3:0] count);
    logic [7:0] fill;
    case (count)
      4'd0:    fill = 8'h00;
      4'd1:    fill = 8'h01;
      4'd2:    fill = 8'h03;
      4'd3:    fill = 8'h07;
      4'd4:    fill = 8'h0F;
      4'd5:    fill = 8'h1F;
      4'd6:    fill = 8'h3F;
      4'd7:    fill = 8'h7F;
      default: fill = 8'hFF;
    endcase
    return fill;
  endfunction

endpackage

[src/scanned_four_digit_gauge_display_top.sv]
// An accepted input transaction goes to the input register, then to the result
// register on out_*. Throughput: one transaction per cycle while out_stall is low;
// the two registers form a two-stage pipeline with per-stage valid flow control.
// Reset (rst_n low, synchronous): pipeline empties, scan index returns to the
// thousands digit, thresholds return to 180 and 200.
// Depends on sfdg_pkg.
module scanned_four_digit_gauge_display_top
  import sfdg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PRESS_W-1:0]  in_pressure,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          out_digit_select,
  output logic [7:0]          out_segments,
  output logic [7:0]          out_bar_pattern,
  output logic                out_low_alarm_led,
  output logic                out_high_alarm_led,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  logic [VALUE_W-1:0] low_thr_r, high_thr_r;
  logic [1:0]         scan_r;

  logic               a_valid_r, a_valid_nxt;
  logic [VALUE_W-1:0] a_value_r;
  logic [VALUE_W-1:0] a_quot_r;
  logic [1:0]         a_idx_r;

  logic               out_valid_r, out_valid_nxt;
  logic [3:0]         out_digit_select_r;
  logic [7:0]         out_segments_r;
  logic [7:0]         out_bar_pattern_r;
  logic               out_low_alarm_led_r;
  logic               out_high_alarm_led_r;

  logic               in_accept, b_move, cfg_write;
  logic [VALUE_W-1:0] in_value;
  logic [PROD_W-1:0]  prod_1000, prod_100, prod_10, prod_mod;
  logic [VALUE_W-1:0] quot_sel;
  logic [VALUE_W-1:0] quot_div10;
  logic [VALUE_W-1:0] digit_full;
  logic [3:0]         digit;
  logic [7:0]         seg_val;
  logic [3:0]         bar_count;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_LOW_THR:  prdata = APB_DW'(low_thr_r);
      REG_HIGH_THR: prdata = APB_DW'(high_thr_r);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r  <= LOW_THR_RST;
      high_thr_r <= HIGH_THR_RST;
    end else if (cfg_write) begin
      if (reg_idx_t'(paddr[2]) == REG_LOW_THR) begin
        low_thr_r <= pwdata[VALUE_W-1:0];
      end else begin
        high_thr_r <= pwdata[VALUE_W-1:0];
      end
    end
  end

  // flow control
  assign b_move    = !out_valid_r || !out_stall;
  assign in_stall  = a_valid_r && !b_move;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (in_accept) begin
      a_valid_nxt = 1'b1;
    end else if (b_move) begin
      a_valid_nxt = 1'b0;
    end else begin
      a_valid_nxt = a_valid_r;
    end
    out_valid_nxt = b_move ? a_valid_r : out_valid_r;
  end

  // input stage: saturate and take the quotient for the scanned digit
  assign in_value  = (in_pressure > PRESS_W'(VALUE_MAX)) ? VALUE_MAX
                                                          : in_pressure[VALUE_W-1:0];
  assign prod_1000 = PROD_W'(in_value) * PROD_W'(RECIP_1000);
  assign prod_100  = PROD_W'(in_value) * PROD_W'(RECIP_100);
  assign prod_10   = PROD_W'(in_value) * PROD_W'(RECIP_10);

  always_comb begin
    case (digit_pos_t'(scan_r))
      DIG_THOUSANDS: quot_sel = VALUE_W'(prod_1000 >> 23);
      DIG_HUNDREDS:  quot_sel = VALUE_W'(prod_100 >> 19);
      DIG_TENS:      quot_sel = VALUE_W'(prod_10 >> 16);
      default:       quot_sel = in_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      scan_r    <= 2'd0;
    end else begin
      a_valid_r <= a_valid_nxt;
      if (in_accept) begin
        scan_r <= scan_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_value_r <= in_value;
      a_quot_r  <= quot_sel;
      a_idx_r   <= scan_r;
    end
  end

  // result stage: digit, segment code, bargraph and alarms
  assign prod_mod   = PROD_W'(a_quot_r) * PROD_W'(RECIP_10);
  assign quot_div10 = VALUE_W'(prod_mod >> 16);
  assign digit_full = a_quot_r - VALUE_W'(quot_div10 * VALUE_W'(10));
  assign digit      = digit_full[3:0];

  always_comb begin
    case (digit_pos_t'(a_idx_r))
      DIG_THOUSANDS: seg_val = (a_quot_r == '0) ? 8'h00 : seg_code(digit);
      DIG_HUNDREDS:  seg_val = seg_code(digit) | DP_BIT;
      default:       seg_val = seg_code(digit);
    endcase
  end

  always_comb begin
    bar_count = '0;
    for (int k = 1; k <= int'(BAR_MAX_COUNT); k++) begin
      if (a_value_r >= VALUE_W'(k * int'(BAR_STEP))) begin
        bar_count = 4'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move && a_valid_r) begin
      out_digit_select_r   <= 4'b0001 << a_idx_r;
      out_segments_r       <= seg_val;
      out_bar_pattern_r    <= bar_fill(bar_count);
      out_low_alarm_led_r  <= a_value_r >= low_thr_r;
      out_high_alarm_led_r <= a_value_r >= high_thr_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_digit_select   = out_digit_select_r;
  assign out_segments       = out_segments_r;
  assign out_bar_pattern    = out_bar_pattern_r;
  assign out_low_alarm_led  = out_low_alarm_led_r;
  assign out_high_alarm_led = out_high_alarm_led_r;

endmodule

[bench/scanned_four_digit_gauge_display_top_test.sv]
// Self-checking bench for scanned_four_digit_gauge_display_top: random and directed
// pressure transactions, threshold writes over the APB port, predicted display outputs.
// Depends on sfdg_pkg and the top-level RTL only.
module scanned_four_digit_gauge_display_top_test;
  import sfdg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0] digit_sel;
    logic [7:0] segs;
    logic [7:0] bar;
    logic       low_led;
    logic       high_led;
  } gauge_view_t;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 31;
  localparam int unsigned SETTLE      = 6;
  localparam logic [7:0] GLYPH [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                        8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [PRESS_W-1:0]  in_pressure = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [3:0]          out_digit_select;
  logic [7:0]          out_segments;
  logic [7:0]          out_bar_pattern;
  logic                out_low_alarm_led;
  logic                out_high_alarm_led;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  logic [PRESS_W-1:0]  pressure_backlog [$];
  gauge_view_t         expected_views [$];
  digit_pos_t          scan_pos = DIG_THOUSANDS;
  logic [VALUE_W-1:0]  low_thr = LOW_THR_RST;
  logic [VALUE_W-1:0]  high_thr = HIGH_THR_RST;
  logic                steady = 1'b0;
  int unsigned         mismatches = 0;
  int unsigned         cycle_count = 0;

  scanned_four_digit_gauge_display_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic gauge_view_t gauge_response(input logic [PRESS_W-1:0] p,
                                                 input digit_pos_t pos,
                                                 input logic [VALUE_W-1:0] lo,
                                                 input logic [VALUE_W-1:0] hi);
    gauge_view_t view;
    int unsigned v;
    int unsigned fill;
    v = (p > 9999) ? 9999 : p;
    view.digit_sel = 4'b0001 << pos;
    case (pos)
      DIG_THOUSANDS: view.segs = (v >= 1000) ? GLYPH[v / 1000] : 8'h00;
      DIG_HUNDREDS:  view.segs = GLYPH[(v / 100) % 10] | 8'h80;
      DIG_TENS:      view.segs = GLYPH[(v / 10) % 10];
      default:       view.segs = GLYPH[v % 10];
    endcase
    fill = v / 20;
    if (fill > 8) fill = 8;
    view.bar = 8'((9'd1 << fill) - 9'd1);
    view.low_led = (v >= lo);
    view.high_led = (v >= hi);
    return view;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      scan_pos = DIG_THOUSANDS;
    end else begin
      if (in_valid && !in_stall) begin
        expected_views.push_back(gauge_response(in_pressure, scan_pos, low_thr, high_thr));
        scan_pos = digit_pos_t'(scan_pos + 2'd1);
      end
      if (!in_valid || !in_stall) begin
        if (pressure_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_pressure <= pressure_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    gauge_view_t want;
    gauge_view_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_digit_select, out_segments, out_bar_pattern,
                out_low_alarm_led, out_high_alarm_led};
        if (expected_views.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: sel=%h seg=%h bar=%h low=%b high=%b",
                     got.digit_sel, got.segs, got.bar, got.low_led, got.high_led);
        end else begin
          want = expected_views.pop_front();
          if (got.digit_sel !== want.digit_sel || got.segs !== want.segs ||
              got.bar !== want.bar || got.low_led !== want.low_led ||
              got.high_led !== want.high_led) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected sel=%h seg=%h bar=%h low=%b high=%b",
                       want.digit_sel, want.segs, want.bar, want.low_led, want.high_led);
              $display("          got      sel=%h seg=%h bar=%h low=%b high=%b",
                       got.digit_sel, got.segs, got.bar, got.low_led, got.high_led);
            end
          end
        end
      end
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL scanned_four_digit_gauge_display_top");
      $finish;
    end
  end

  task automatic write_threshold(input reg_idx_t which, input logic [APB_DW-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(which) << 2;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (which == REG_LOW_THR) low_thr = data[VALUE_W-1:0];
    else high_thr = data[VALUE_W-1:0];
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pressure_backlog.size() != 0 || in_valid || expected_views.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [PRESS_W-1:0] pick_pressure();
    int unsigned roll;
    int t;
    roll = $urandom_range(0, 99);
    if (roll < 45) return PRESS_W'($urandom_range(0, 9999));
    if (roll < 60) begin
      t = ($urandom_range(0, 1) ? int'(low_thr) : int'(high_thr)) + $urandom_range(0, 6) - 3;
      if (t < 0) t = 0;
      return PRESS_W'(t);
    end
    if (roll < 75) return PRESS_W'($urandom_range(0, 200));
    if (roll < 82) return PRESS_W'($urandom_range(990, 1010));
    if (roll < 90) return PRESS_W'($urandom_range(9990, 65535));
    return PRESS_W'($urandom);
  endfunction

  task automatic run_random(input int unsigned count);
    repeat (count) pressure_backlog.push_back(pick_pressure());
    drain();
  endtask

  task automatic set_thresholds(input logic [APB_DW-1:0] lo, input logic [APB_DW-1:0] hi);
    write_threshold(REG_LOW_THR, lo);
    write_threshold(REG_HIGH_THR, hi);
  endtask

  initial begin
    static logic [PRESS_W-1:0] quad [5] = '{16'd0, 16'd999, 16'd1000, 16'd9999, 16'd65535};
    static logic [PRESS_W-1:0] single [5] = '{16'd19, 16'd20, 16'd160, 16'd180, 16'd199};
    @(posedge rst_n);
    foreach (quad[i]) repeat (4) pressure_backlog.push_back(quad[i]);
    foreach (single[i]) pressure_backlog.push_back(single[i]);
    drain();
    run_random(120);

    set_thresholds(32'd0, 32'd0);
    run_random(150);
    set_thresholds(32'd9999, 32'd9999);
    run_random(150);
    set_thresholds(32'hFFFF_FFFF, 32'd10000);
    run_random(150);

    repeat (5) begin
      set_thresholds({18'($urandom_range(0, 262143)), 14'($urandom_range(0, 9999))},
                     {18'($urandom_range(0, 262143)), 14'($urandom_range(0, 9999))});
      run_random(120);
    end

    steady = 1'b1;
    set_thresholds(32'd500, 32'd250);
    run_random(100);
    steady = 1'b0;

    if (mismatches == 0) begin
      $display("PASS scanned_four_digit_gauge_display_top");
    end else begin
      $display("FAIL scanned_four_digit_gauge_display_top");
    end
    $finish;
  end

endmodule
